FILE: design/pfu_pkg.sv
// ----------------------------------------------------------------------------
// pfu_pkg
// Shared types and constants for the packed field unpacker.
// ----------------------------------------------------------------------------
package pfu_pkg;

    localparam int VALUE_BITS = 64;
    localparam int WIDTH_BITS = 7;
    localparam int BUF_BITS   = 72;
    localparam int BYTE_BITS  = 8;
    localparam int INDEX_BITS = 2;

    localparam logic [INDEX_BITS-1:0] REG_VALUE_WIDTH   = 2'd0;
    localparam logic [INDEX_BITS-1:0] REG_VALUE_MINIMUM = 2'd1;
    localparam logic [INDEX_BITS-1:0] REG_RECORD_COUNT  = 2'd2;

    localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = 7'd8;
    localparam logic [WIDTH_BITS-1:0] WIDTH_MAX   = 7'd64;
    localparam logic [WIDTH_BITS-1:0] WIDTH_MIN   = 7'd1;
    localparam logic [WIDTH_BITS-1:0] BYTE_FILL   = 7'd8;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EMIT
    } state_t;

endpackage

FILE: design/packed_field_unpacker_core.sv
// ----------------------------------------------------------------------------
// packed_field_unpacker_core
// Unpacks LSB-first bit-packed values of one field from a bytestream.
// ----------------------------------------------------------------------------
// Each accepted byte is appended above the bits held in a 72-bit buffer. The
// block then peels value_width bits at a time off the bottom of the buffer,
// one value per cycle, adds value_minimum (64-bit wrap) and presents the sum
// on the output item register. An input byte is first appended; each value it
// then completes (0 to 8 values) is taken in turn, and a byte that completes
// no value gets a closing step back to idle. Every value waits for
// the output register to be free, so output stall holds the flow. The
// single shift/mask/add path on the buffer sets this rate. in_stall stays high
// from the accepted byte until its last value is loaded into the output
// register. last_of_byte marks the last value a byte produces; final_record
// marks the value that uses up record_count, after which bytes are accepted
// and dropped until record_count is written again. Writing value_width or
// record_count clears the buffer; write configuration only while idle.
// ----------------------------------------------------------------------------
module packed_field_unpacker_core #(
    parameter int COUNT_BITS = 40
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration write port
    input  logic                                 cfg_write,
    input  logic [pfu_pkg::INDEX_BITS-1:0]       cfg_index,
    input  logic [pfu_pkg::VALUE_BITS-1:0]       cfg_data,
    // input channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [pfu_pkg::BYTE_BITS-1:0]        stream_byte,
    // output channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [pfu_pkg::VALUE_BITS-1:0] value,
    output logic                                 last_of_byte,
    output logic                                 final_record
);

    // configuration registers
    logic [pfu_pkg::WIDTH_BITS-1:0] width_reg;
    logic [pfu_pkg::VALUE_BITS-1:0] minimum_reg;

    // working state
    pfu_pkg::state_t                state_reg, state_next;
    logic [pfu_pkg::BUF_BITS-1:0]   buf_reg, buf_next;
    logic [pfu_pkg::WIDTH_BITS-1:0] fill_reg, fill_next;
    logic [COUNT_BITS-1:0]          records_reg, records_next;

    // output item register
    logic                           out_valid_reg, out_valid_next;
    logic [pfu_pkg::VALUE_BITS-1:0] value_reg, value_next;
    logic                           last_reg, last_next;
    logic                           final_reg, final_next;

    // shared datapath
    logic [pfu_pkg::WIDTH_BITS-1:0] w_eff;
    logic [pfu_pkg::VALUE_BITS-1:0] take_mask;
    logic [pfu_pkg::VALUE_BITS-1:0] take_sum;
    logic [pfu_pkg::BUF_BITS-1:0]   buf_shifted;
    logic [pfu_pkg::BUF_BITS-1:0]   buf_appended;
    logic [pfu_pkg::WIDTH_BITS-1:0] fill_rem;
    logic                           can_take;
    logic                           slot_free;
    logic                           records_one;
    logic                           in_accept;

    // Clamp the width: zero acts as one, anything above 64 acts as 64.
    always_comb
    begin
        if (width_reg == '0)
            w_eff = pfu_pkg::WIDTH_MIN;
        else if (width_reg > pfu_pkg::WIDTH_MAX)
            w_eff = pfu_pkg::WIDTH_MAX;
        else
            w_eff = width_reg;
    end

    // One shift/mask/add unit, reused for every value of the byte.
    always_comb
    begin
        if (w_eff == pfu_pkg::WIDTH_MAX)
            take_mask = '1;
        else
            take_mask = (pfu_pkg::VALUE_BITS'(1) << w_eff) - pfu_pkg::VALUE_BITS'(1);
        take_sum     = (buf_reg[pfu_pkg::VALUE_BITS-1:0] & take_mask) + minimum_reg;
        buf_shifted  = buf_reg >> w_eff;
        buf_appended = buf_reg | (pfu_pkg::BUF_BITS'(stream_byte) << fill_reg);
        fill_rem     = fill_reg - w_eff;
    end

    assign records_one = (records_reg == COUNT_BITS'(1));
    assign can_take    = (fill_reg >= w_eff) && (records_reg != '0);
    assign slot_free   = !out_valid_reg || !out_stall;
    assign in_accept   = in_valid && (state_reg == pfu_pkg::ST_IDLE);

    // Sequencer: append in IDLE, then peel values in EMIT.
    always_comb
    begin
        state_next     = state_reg;
        buf_next       = buf_reg;
        fill_next      = fill_reg;
        records_next   = records_reg;
        out_valid_next = out_valid_reg && out_stall;
        value_next     = value_reg;
        last_next      = last_reg;
        final_next     = final_reg;

        case (state_reg)
            pfu_pkg::ST_IDLE:
            begin
                // drop the byte when no records remain
                if (in_accept && (records_reg != '0))
                begin
                    buf_next   = buf_appended;
                    fill_next  = fill_reg + pfu_pkg::BYTE_FILL;
                    state_next = pfu_pkg::ST_EMIT;
                end
            end
            pfu_pkg::ST_EMIT:
            begin
                if (!can_take)
                    state_next = pfu_pkg::ST_IDLE;
                else if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    value_next     = take_sum;
                    last_next      = (fill_rem < w_eff) || records_one;
                    final_next     = records_one;
                    buf_next       = buf_shifted;
                    fill_next      = fill_rem;
                    records_next   = records_reg - COUNT_BITS'(1);
                    // advance to idle once this byte is exhausted or the last record is taken
                    if ((fill_rem < w_eff) || records_one)
                        state_next = pfu_pkg::ST_IDLE;
                end
            end
            default:
                state_next = pfu_pkg::ST_IDLE;
        endcase

        // configuration writes must arrive only while idle; the block does not enforce it
        if (cfg_write)
        begin
            if (cfg_index == pfu_pkg::REG_VALUE_WIDTH)
            begin
                buf_next  = '0;
                fill_next = '0;
            end
            else if (cfg_index == pfu_pkg::REG_RECORD_COUNT)
            begin
                buf_next     = '0;
                fill_next    = '0;
                records_next = cfg_data[COUNT_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pfu_pkg::ST_IDLE;
            buf_reg       <= '0;
            fill_reg      <= '0;
            records_reg   <= '0;
            out_valid_reg <= 1'b0;
            width_reg     <= pfu_pkg::WIDTH_RESET;
            minimum_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            buf_reg       <= buf_next;
            fill_reg      <= fill_next;
            records_reg   <= records_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write && (cfg_index == pfu_pkg::REG_VALUE_WIDTH))
                width_reg <= cfg_data[pfu_pkg::WIDTH_BITS-1:0];
            if (cfg_write && (cfg_index == pfu_pkg::REG_VALUE_MINIMUM))
                minimum_reg <= cfg_data;
        end
    end

    // output payload: hold while stalled
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        last_reg  <= last_next;
        final_reg <= final_next;
    end

    assign in_stall     = (state_reg != pfu_pkg::ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign value        = value_reg;
    assign last_of_byte = last_reg;
    assign final_record = final_reg;

endmodule

FILE: design/pfu_checker.sv
// ----------------------------------------------------------------------------
// pfu_checker
// Port-level assertions for the packed field unpacker, bound to the top level.
// ----------------------------------------------------------------------------
module pfu_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_stall,
    input logic                                 out_valid,
    input logic                                 out_stall,
    input logic signed [pfu_pkg::VALUE_BITS-1:0] value,
    input logic                                 last_of_byte,
    input logic                                 final_record
);

    // a stalled item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(value))
        else $error("output item changed while stalled");

    // the final record always closes its byte
    a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && final_record |-> last_of_byte)
        else $error("final record without last_of_byte");

    // more values of the byte pending: input must stay stalled
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall && !last_of_byte |=> in_stall)
        else $error("input taken while a byte still has values pending");

    // nothing follows the final record in the next cycle
    a_final_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && final_record && !out_stall |=> !out_valid)
        else $error("item emitted right after the final record");

endmodule

bind packed_field_unpacker_core pfu_checker u_pfu_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .value        (value),
    .last_of_byte (last_of_byte),
    .final_record (final_record)
);
